### rtl/na_pkg.sv
`default_nettype none

package na_pkg;

    // Default depth of the held and sounding note lists
    localparam int MAX_HELD_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SOURCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARP_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_SPAN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD  = 3'd4;

    // Input function codes
    localparam logic [2:0] FUNC_NOTE_ON  = 3'd0;
    localparam logic [2:0] FUNC_NOTE_OFF = 3'd1;
    localparam logic [2:0] FUNC_ADVANCE  = 3'd2;
    localparam logic [2:0] FUNC_STEP     = 3'd3;
    localparam logic [2:0] FUNC_STOP     = 3'd4;

    // Clock source codes
    localparam logic CLK_INTERNAL = 1'b0;
    localparam logic CLK_HOST     = 1'b1;

    // Arpeggio modes
    localparam logic [1:0] MODE_UP     = 2'd0;
    localparam logic [1:0] MODE_BOUNCE = 2'd1;
    localparam logic [1:0] MODE_RANDOM = 2'd2;
    localparam logic [1:0] MODE_CHORD  = 2'd3;

    // Result event kinds
    localparam logic KIND_OFF = 1'b0;
    localparam logic KIND_ON  = 1'b1;

    localparam logic [6:0]  VEL_ON     = 7'd120;
    localparam logic [6:0]  VEL_OFF    = 7'd0;
    localparam logic [6:0]  PITCH_MAX  = 7'd127;
    localparam logic [7:0]  OCT_SEMIS  = 8'd12;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    // Register reset values
    localparam logic        RST_ENABLED      = 1'b1;
    localparam logic        RST_CLOCK_SOURCE = CLK_INTERNAL;
    localparam logic [1:0]  RST_ARP_MODE     = MODE_UP;
    localparam logic [2:0]  RST_OCTAVE_SPAN  = 3'd1;
    localparam logic [23:0] RST_STEP_PERIOD  = 24'd5512;

    typedef struct packed {
        logic        enabled;
        logic        clock_source;
        logic [1:0]  arp_mode;
        logic [2:0]  octave_span;
        logic [23:0] step_period;
    } t_cfg;

    // Command classes passed from the front end to the sequencer
    typedef enum logic [1:0] {
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_STEP,
        OP_STOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] note;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/na_rem.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle
module na_rem #(
    parameter int W_N = 16,
    parameter int W_D = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W_N-1:0] i_num,
    input  wire logic [W_D-1:0] i_den,
    output logic                o_done,
    output logic [W_D-1:0]      o_rem
);

    localparam int CNT_W = $clog2(W_N + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W_N-1:0]   r_num;
    logic [W_D-1:0]   r_den;
    logic [W_D-1:0]   r_rem;
    logic [W_D:0]     w_trial;
    logic [W_D:0]     w_next;

    // Shift in one bit and subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_num[W_N-1]};
        if (w_trial >= {1'b0, r_den}) begin
            w_next = w_trial - {1'b0, r_den};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W_N);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_next[W_D-1:0];
                r_num <= {r_num[W_N-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### rtl/na_queue.sv
`default_nettype none

// Two-entry command queue between front end and sequencer
module na_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire na_pkg::t_cmd i_cmd,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output na_pkg::t_cmd      o_cmd
);

    logic [1:0]   r_cnt;
    logic         r_wp;
    logic         r_rp;
    na_pkg::t_cmd r_slot [2];
    logic         w_push;
    logic         w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Hold entries and advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_slot[r_wp] <= i_cmd;
                r_wp         <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/na_front.sv
`default_nettype none

// Front end: accept transactions, filter them, run the sample clock
module na_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire na_pkg::t_cfg i_cfg,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [2:0]   i_func,
    input  wire logic [6:0]   i_note,
    input  wire logic [12:0]  i_sample_count,
    output logic              o_push,
    output na_pkg::t_cmd      o_cmd,
    input  wire logic         i_q_full
);

    typedef enum logic {F_IDLE, F_DIV} t_fstate;

    t_fstate     r_state, n_state;
    logic [23:0] r_acc, n_acc;
    logic [23:0] w_period;
    logic [24:0] w_sum;
    logic        w_accept;
    logic        w_rem_start;
    logic        w_rem_done;
    logic [23:0] w_rem;

    assign o_in_stall = (r_state != F_IDLE) || i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_period   = (i_cfg.step_period == 24'd0) ? 24'd1 : i_cfg.step_period;
    assign w_sum      = {1'b0, r_acc} + 25'(i_sample_count);

    // Classify the transaction and decide what goes to the queue
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        w_rem_start = 1'b0;
        o_push      = 1'b0;
        o_cmd.op    = na_pkg::OP_STEP;
        o_cmd.note  = i_note;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept && i_cfg.enabled) begin
                    unique case (i_func)
                        na_pkg::FUNC_NOTE_ON: begin
                            o_push   = 1'b1;
                            o_cmd.op = na_pkg::OP_NOTE_ON;
                        end
                        na_pkg::FUNC_NOTE_OFF: begin
                            o_push   = 1'b1;
                            o_cmd.op = na_pkg::OP_NOTE_OFF;
                        end
                        na_pkg::FUNC_ADVANCE: begin
                            if (i_cfg.clock_source == na_pkg::CLK_INTERNAL) begin
                                if (w_sum >= {1'b0, w_period}) begin
                                    w_rem_start = 1'b1;
                                    n_state     = F_DIV;
                                end else begin
                                    n_acc = w_sum[23:0];
                                end
                            end
                        end
                        na_pkg::FUNC_STEP: begin
                            if (i_cfg.clock_source == na_pkg::CLK_HOST) begin
                                o_push   = 1'b1;
                                o_cmd.op = na_pkg::OP_STEP;
                            end
                        end
                        na_pkg::FUNC_STOP: begin
                            if (i_cfg.clock_source == na_pkg::CLK_HOST) begin
                                o_push   = 1'b1;
                                o_cmd.op = na_pkg::OP_STOP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            F_DIV: begin
                if (w_rem_done) begin
                    n_acc    = w_rem;
                    o_push   = 1'b1;
                    o_cmd.op = na_pkg::OP_STEP;
                    n_state  = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
    end

    // Reduce the accumulator modulo the period
    na_rem #(
        .W_N (25),
        .W_D (24)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_num   (w_sum),
        .i_den   (w_period),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

endmodule

`default_nettype wire

### rtl/na_back.sv
`default_nettype none

// Sequencer: keeps held and sounding lists and plays the steps
module na_back #(
    parameter int MAX_HELD = na_pkg::MAX_HELD_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire na_pkg::t_cfg i_cfg,
    input  wire logic         i_q_valid,
    input  wire na_pkg::t_cmd i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_event_kind,
    output logic [6:0]        o_pitch,
    output logic [6:0]        o_velocity,
    output logic              o_last
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SRCH_RD,
        B_SRCH_CHK,
        B_SHIFT_RD,
        B_SHIFT_WR,
        B_REL_RD,
        B_REL_EMIT,
        B_PICK,
        B_POS_WAIT,
        B_PLAY_RD,
        B_PLAY_EMIT,
        B_OCT
    } t_bstate;

    function automatic logic [2:0] oct_wrap(input logic [2:0] a, input logic [2:0] b);
        logic [2:0] v;
        v = a;
        for (int k = 0; k < 7; k++) begin
            if (v >= b) begin
                v = v - b;
            end
        end
        return v;
    endfunction

    t_bstate              r_state, n_state;
    na_pkg::t_cmd         r_cmd, n_cmd;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_hcnt, n_hcnt;
    logic [CW-1:0]        r_scnt, n_scnt;
    logic signed [CW-1:0] r_pos, n_pos;
    logic                 r_up, n_up;
    logic [2:0]           r_oct, n_oct;
    logic [15:0]          r_lfsr, n_lfsr;
    logic                 r_ov, n_ov;
    logic                 r_kind, n_kind;
    logic [6:0]           r_pitch, n_pitch;
    logic [6:0]           r_vel, n_vel;
    logic                 r_last, n_last;

    logic [6:0]           held_mem [MAX_HELD];
    logic [6:0]           snd_mem  [MAX_HELD];
    logic [6:0]           r_hdata;
    logic [6:0]           r_sdata;

    logic [AW-1:0]        w_hra;
    logic                 w_hwe;
    logic [AW-1:0]        w_hwa;
    logic                 w_swe;
    logic [AW-1:0]        w_swa;
    logic [6:0]           w_swd;

    logic                 w_free;
    logic [CW-1:0]        w_inext;
    logic [CW-1:0]        w_up_num;
    logic [15:0]          w_lfsr_step;
    logic [7:0]           w_shift_sum;
    logic [6:0]           w_play_pitch;
    logic signed [CW:0]   w_cur;
    logic signed [CW:0]   w_top;
    logic signed [CW:0]   w_nxt;
    logic                 w_up_dir;
    logic                 w_rem_start;
    logic [15:0]          w_rem_num;
    logic                 w_rem_done;
    logic [CW-1:0]        w_rem;

    assign w_free   = !r_ov || !i_out_stall;
    assign w_inext  = r_i + CW'(1);
    assign w_up_num = CW'(r_pos) + CW'(1);

    // Next random value, one Galois shift
    assign w_lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ na_pkg::LFSR_TAPS) : (r_lfsr >> 1);

    // Held note plus octave offset, saturated
    assign w_shift_sum  = {1'b0, r_hdata} + 8'(r_oct) * na_pkg::OCT_SEMIS;
    assign w_play_pitch = (w_shift_sum > {1'b0, na_pkg::PITCH_MAX}) ?
                          na_pkg::PITCH_MAX : w_shift_sum[6:0];

    // Bounce: turn at the ends, move one step, clamp into the list
    always_comb begin
        w_cur = {r_pos[CW-1], r_pos};
        w_top = $signed({1'b0, r_hcnt}) - $signed((CW+1)'(1));
        if (w_cur <= $signed((CW+1)'(0))) begin
            w_up_dir = 1'b1;
        end else if (w_cur >= w_top) begin
            w_up_dir = 1'b0;
        end else begin
            w_up_dir = r_up;
        end
        w_nxt = w_up_dir ? (w_cur + $signed((CW+1)'(1))) : (w_cur - $signed((CW+1)'(1)));
        if (w_nxt < $signed((CW+1)'(0))) begin
            w_nxt = '0;
        end
        if (w_nxt > w_top) begin
            w_nxt = w_top;
        end
    end

    assign w_hra = (r_state == B_SHIFT_RD) ? w_inext[AW-1:0] : r_i[AW-1:0];

    // Sequence list edits, releases and plays
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_i         = r_i;
        n_hcnt      = r_hcnt;
        n_scnt      = r_scnt;
        n_pos       = r_pos;
        n_up        = r_up;
        n_oct       = r_oct;
        n_lfsr      = r_lfsr;
        n_ov        = r_ov && i_out_stall;
        n_kind      = r_kind;
        n_pitch     = r_pitch;
        n_vel       = r_vel;
        n_last      = r_last;
        o_q_pop     = 1'b0;
        w_hwe       = 1'b0;
        w_hwa       = r_i[AW-1:0];
        w_swe       = 1'b0;
        w_swa       = r_i[AW-1:0];
        w_swd       = w_play_pitch;
        w_rem_start = 1'b0;
        w_rem_num   = 16'(w_up_num);
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_i     = '0;
                    if (i_q_cmd.op == na_pkg::OP_NOTE_ON ||
                        i_q_cmd.op == na_pkg::OP_NOTE_OFF) begin
                        n_state = B_SRCH_RD;
                    end else if (r_scnt != '0) begin
                        n_state = B_REL_RD;
                    end else if (i_q_cmd.op == na_pkg::OP_STOP) begin
                        n_state = B_IDLE;
                    end else begin
                        n_state = B_PICK;
                    end
                end
            end
            B_SRCH_RD: begin
                if (r_i == r_hcnt) begin
                    // Not present: append on note on if there is room
                    if (r_cmd.op == na_pkg::OP_NOTE_ON && r_hcnt < CW'(MAX_HELD)) begin
                        w_hwe  = 1'b1;
                        w_hwa  = r_hcnt[AW-1:0];
                        n_hcnt = r_hcnt + CW'(1);
                    end
                    n_state = B_IDLE;
                end else begin
                    n_state = B_SRCH_CHK;
                end
            end
            B_SRCH_CHK: begin
                if (r_hdata == r_cmd.note) begin
                    n_state = (r_cmd.op == na_pkg::OP_NOTE_OFF) ? B_SHIFT_RD : B_IDLE;
                end else begin
                    n_i     = w_inext;
                    n_state = B_SRCH_RD;
                end
            end
            B_SHIFT_RD: begin
                if (w_inext < r_hcnt) begin
                    n_state = B_SHIFT_WR;
                end else begin
                    n_hcnt  = r_hcnt - CW'(1);
                    n_state = B_IDLE;
                end
            end
            B_SHIFT_WR: begin
                // Close the gap one entry at a time
                w_hwe   = 1'b1;
                n_i     = w_inext;
                n_state = B_SHIFT_RD;
            end
            B_REL_RD: begin
                n_state = B_REL_EMIT;
            end
            B_REL_EMIT: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_kind  = na_pkg::KIND_OFF;
                    n_pitch = r_sdata;
                    n_vel   = na_pkg::VEL_OFF;
                    n_last  = 1'b0;
                    if (w_inext == r_scnt) begin
                        n_last  = (r_cmd.op == na_pkg::OP_STOP) || (r_hcnt == '0);
                        n_scnt  = '0;
                        n_i     = '0;
                        n_state = (r_cmd.op == na_pkg::OP_STOP) ? B_IDLE : B_PICK;
                    end else begin
                        n_i     = w_inext;
                        n_state = B_REL_RD;
                    end
                end
            end
            B_PICK: begin
                n_i = '0;
                if (r_hcnt == '0) begin
                    n_state = B_OCT;
                end else begin
                    unique case (i_cfg.arp_mode)
                        na_pkg::MODE_UP: begin
                            w_rem_start = 1'b1;
                            n_state     = B_POS_WAIT;
                        end
                        na_pkg::MODE_BOUNCE: begin
                            n_up    = w_up_dir;
                            n_pos   = w_nxt[CW-1:0];
                            n_i     = w_nxt[CW-1:0];
                            n_state = B_PLAY_RD;
                        end
                        na_pkg::MODE_RANDOM: begin
                            n_lfsr      = w_lfsr_step;
                            w_rem_num   = w_lfsr_step;
                            w_rem_start = 1'b1;
                            n_state     = B_POS_WAIT;
                        end
                        na_pkg::MODE_CHORD: begin
                            n_state = B_PLAY_RD;
                        end
                        default: begin
                            n_state = B_OCT;
                        end
                    endcase
                end
            end
            B_POS_WAIT: begin
                if (w_rem_done) begin
                    n_pos   = $signed(w_rem);
                    n_i     = w_rem;
                    n_state = B_PLAY_RD;
                end
            end
            B_PLAY_RD: begin
                n_state = B_PLAY_EMIT;
            end
            B_PLAY_EMIT: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_kind  = na_pkg::KIND_ON;
                    n_pitch = w_play_pitch;
                    n_vel   = na_pkg::VEL_ON;
                    w_swe   = 1'b1;
                    if (i_cfg.arp_mode == na_pkg::MODE_CHORD) begin
                        n_last = (w_inext == r_hcnt);
                        if (w_inext == r_hcnt) begin
                            n_scnt  = r_hcnt;
                            n_state = B_OCT;
                        end else begin
                            n_i     = w_inext;
                            n_state = B_PLAY_RD;
                        end
                    end else begin
                        w_swa   = '0;
                        n_last  = 1'b1;
                        n_scnt  = CW'(1);
                        n_state = B_OCT;
                    end
                end
            end
            B_OCT: begin
                if (i_cfg.octave_span != 3'd0) begin
                    n_oct = oct_wrap(r_oct + 3'd1, i_cfg.octave_span);
                end
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Held and sounding note memories
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            held_mem[w_hwa] <= (r_state == B_SHIFT_WR) ? r_hdata : r_cmd.note;
        end
        if (w_swe) begin
            snd_mem[w_swa] <= w_swd;
        end
        r_hdata <= held_mem[w_hra];
        r_sdata <= snd_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_i     <= '0;
            r_hcnt  <= '0;
            r_scnt  <= '0;
            r_pos   <= '1;
            r_up    <= 1'b1;
            r_oct   <= '0;
            r_lfsr  <= na_pkg::LFSR_SEED;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_hcnt  <= n_hcnt;
            r_scnt  <= n_scnt;
            r_pos   <= n_pos;
            r_up    <= n_up;
            r_oct   <= n_oct;
            r_lfsr  <= n_lfsr;
            r_ov    <= n_ov;
        end
        r_cmd   <= n_cmd;
        r_kind  <= n_kind;
        r_pitch <= n_pitch;
        r_vel   <= n_vel;
        r_last  <= n_last;
    end

    // Position modulo the held count
    na_rem #(
        .W_N (16),
        .W_D (CW)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_num   (w_rem_num),
        .i_den   (r_hcnt),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    assign o_out_valid  = r_ov;
    assign o_event_kind = r_kind;
    assign o_pitch      = r_pitch;
    assign o_velocity   = r_vel;
    assign o_last       = r_last;

endmodule

`default_nettype wire

### rtl/note_arpeggiator.sv
// Note arpeggiator. Note on and note off transactions edit an insertion-ordered
// list of up to MAX_HELD held notes; advance transactions (internal clock) or
// host step transactions (host clock) play one arpeggio step, which first emits
// a note off for every sounding pitch and then a note on for the next held note
// (up, bounce, random) or for all held notes (chord); host stop releases only.
// The final result of a transaction carries o_last. The front end takes one
// transaction a cycle while its two-entry queue has room; an advance that
// crosses the step period holds the input while the accumulator is reduced
// one bit a cycle. The sequencer searches the held list one entry at a time on
// a note on or off, and on a note off moves the later entries down one at a
// time; a step releases the sounding notes one at a time and then plays, using
// a serial remainder to pick the position in up and random order. Output
// stalls hold the sequencer back.
`default_nettype none

module note_arpeggiator #(
    parameter int MAX_HELD = na_pkg::MAX_HELD_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [na_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [na_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [2:0]                    i_func,
    input  wire logic [6:0]                    i_note,
    input  wire logic [12:0]                   i_sample_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_event_kind,
    output logic [6:0]                         o_pitch,
    output logic [6:0]                         o_velocity,
    output logic                               o_last
);

    na_pkg::t_cfg r_cfg;
    logic         w_push;
    na_pkg::t_cmd w_push_cmd;
    logic         w_q_full;
    logic         w_q_valid;
    na_pkg::t_cmd w_q_cmd;
    logic         w_q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled      <= na_pkg::RST_ENABLED;
            r_cfg.clock_source <= na_pkg::RST_CLOCK_SOURCE;
            r_cfg.arp_mode     <= na_pkg::RST_ARP_MODE;
            r_cfg.octave_span  <= na_pkg::RST_OCTAVE_SPAN;
            r_cfg.step_period  <= na_pkg::RST_STEP_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                na_pkg::REG_ENABLED:      r_cfg.enabled      <= i_cfg_data[0];
                na_pkg::REG_CLOCK_SOURCE: r_cfg.clock_source <= i_cfg_data[0];
                na_pkg::REG_ARP_MODE:     r_cfg.arp_mode     <= i_cfg_data[1:0];
                na_pkg::REG_OCTAVE_SPAN:  r_cfg.octave_span  <= i_cfg_data[2:0];
                na_pkg::REG_STEP_PERIOD:  r_cfg.step_period  <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    na_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_note         (i_note),
        .i_sample_count (i_sample_count),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd),
        .i_q_full       (w_q_full)
    );

    na_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    na_back #(
        .MAX_HELD (MAX_HELD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_pitch      (o_pitch),
        .o_velocity   (o_velocity),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### test/note_arpeggiator_tb.sv
`timescale 1ns / 1ps

module note_arpeggiator_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HELD_MAX       = na_pkg::MAX_HELD_DEF;

    typedef struct packed {
        logic       kind;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic       last;
    } t_arp_event;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [na_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [na_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [2:0]                    i_func = '0;
    logic [6:0]                    i_note = '0;
    logic [12:0]                   i_sample_count = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_event_kind;
    logic [6:0]                    o_pitch;
    logic [6:0]                    o_velocity;
    logic                          o_last;

    note_arpeggiator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_note         (i_note),
        .i_sample_count (i_sample_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_pitch        (o_pitch),
        .o_velocity     (o_velocity),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predicted configuration and arpeggiator state
    logic        arp_en;
    logic        arp_src;
    logic [1:0]  arp_mode;
    logic [2:0]  arp_span;
    logic [23:0] arp_period;
    logic [6:0]  held_notes [HELD_MAX];
    int          held_n;
    logic [6:0]  sounding [HELD_MAX];
    int          sounding_n;
    int          position;
    bit          going_up;
    int          octave;
    int unsigned sample_acc;
    logic [15:0] lfsr;

    t_arp_event  expected_events [$];
    t_arp_event  step_events [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;
    int          quiet_cycles = 0;

    task automatic push_event(input logic kind, input logic [6:0] pitch);
        t_arp_event ev;
        ev.kind     = kind;
        ev.pitch    = pitch;
        ev.velocity = kind ? na_pkg::VEL_ON : na_pkg::VEL_OFF;
        ev.last     = 1'b0;
        step_events.push_back(ev);
    endtask

    task automatic release_sounding();
        for (int i = 0; i < sounding_n; i++) push_event(na_pkg::KIND_OFF, sounding[i]);
        sounding_n = 0;
    endtask

    function automatic logic [6:0] octave_pitch(input logic [6:0] n);
        int p;
        p = n + 12 * octave;
        return (p > 127) ? na_pkg::PITCH_MAX : p[6:0];
    endfunction

    task automatic play_step();
        logic [6:0] p;
        int nxt;
        release_sounding();
        if (held_n > 0) begin
            if (arp_mode == na_pkg::MODE_CHORD) begin
                for (int i = 0; i < held_n; i++) begin
                    p = octave_pitch(held_notes[i]);
                    push_event(na_pkg::KIND_ON, p);
                    sounding[sounding_n++] = p;
                end
            end else begin
                case (arp_mode)
                    na_pkg::MODE_UP: nxt = (position + 1) % held_n;
                    na_pkg::MODE_BOUNCE: begin
                        if (position <= 0) going_up = 1'b1;
                        else if (position >= held_n - 1) going_up = 1'b0;
                        nxt = going_up ? position + 1 : position - 1;
                        if (nxt < 0) nxt = 0;
                        if (nxt > held_n - 1) nxt = held_n - 1;
                    end
                    default: begin
                        lfsr = lfsr[0] ? ((lfsr >> 1) ^ na_pkg::LFSR_TAPS) : (lfsr >> 1);
                        nxt = lfsr % held_n;
                    end
                endcase
                position = nxt;
                p = octave_pitch(held_notes[position]);
                push_event(na_pkg::KIND_ON, p);
                sounding[0] = p;
                sounding_n = 1;
            end
        end
        if (arp_span > 0) octave = (octave + 1) % arp_span;
    endtask

    // Work out the results of one accepted transaction
    task automatic predict_events(input logic [2:0] f, input logic [6:0] n,
                                  input logic [12:0] c);
        int unsigned per;
        bit found;
        t_arp_event ev;
        step_events = {};
        if (!arp_en) return;
        found = 0;
        case (f)
            na_pkg::FUNC_NOTE_ON: begin
                for (int i = 0; i < held_n; i++) if (held_notes[i] == n) found = 1;
                if (!found && held_n < HELD_MAX) held_notes[held_n++] = n;
            end
            na_pkg::FUNC_NOTE_OFF: begin
                for (int i = 0; i < held_n && !found; i++) begin
                    if (held_notes[i] == n) begin
                        found = 1;
                        for (int j = i; j + 1 < held_n; j++) held_notes[j] = held_notes[j + 1];
                        held_n--;
                    end
                end
            end
            na_pkg::FUNC_ADVANCE: if (arp_src == na_pkg::CLK_INTERNAL) begin
                per = (arp_period == 0) ? 1 : arp_period;
                sample_acc += c;
                if (sample_acc >= per) begin
                    sample_acc = sample_acc % per;
                    play_step();
                end
            end
            na_pkg::FUNC_STEP: if (arp_src == na_pkg::CLK_HOST) play_step();
            na_pkg::FUNC_STOP: if (arp_src == na_pkg::CLK_HOST) release_sounding();
            default: ;
        endcase
        if (step_events.size() > 0) begin
            ev = step_events.pop_back();
            ev.last = 1'b1;
            step_events.push_back(ev);
        end
        foreach (step_events[i]) expected_events.push_back(step_events[i]);
    endtask

    task automatic reset_model();
        arp_en = na_pkg::RST_ENABLED;
        arp_src = na_pkg::RST_CLOCK_SOURCE;
        arp_mode = na_pkg::RST_ARP_MODE;
        arp_span = na_pkg::RST_OCTAVE_SPAN;
        arp_period = na_pkg::RST_STEP_PERIOD;
        held_n = 0;
        sounding_n = 0;
        position = -1;
        going_up = 1'b1;
        octave = 0;
        sample_acc = 0;
        lfsr = na_pkg::LFSR_SEED;
    endtask

    // Offer one transaction, with a random gap before it
    task automatic send_item(input logic [2:0] f, input logic [6:0] n,
                             input logic [12:0] c);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_note         <= n;
        i_sample_count <= c;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_events(f, n, c);
    endtask

    // Drop valid and wait until the block has gone quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_events.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [na_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            na_pkg::REG_ENABLED:      arp_en = data[0];
            na_pkg::REG_CLOCK_SOURCE: arp_src = data[0];
            na_pkg::REG_ARP_MODE:     arp_mode = data[1:0];
            na_pkg::REG_OCTAVE_SPAN:  arp_span = data[2:0];
            na_pkg::REG_STEP_PERIOD:  arp_period = data;
            default: ;
        endcase
    endtask

    // Check each accepted result against the oldest expectation; drive stall
    always @(posedge i_clk) begin
        t_arp_event want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind %0d pitch %0d vel %0d last %0d",
                             o_event_kind, o_pitch, o_velocity, o_last);
            end else begin
                want = expected_events.pop_front();
                if (want !== {o_event_kind, o_pitch, o_velocity, o_last}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected kind %0d pitch %0d vel %0d last %0d,",
                                  " got kind %0d pitch %0d vel %0d last %0d"},
                                 want.kind, want.pitch, want.velocity, want.last,
                                 o_event_kind, o_pitch, o_velocity, o_last);
                end
            end
        end
        if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(na_pkg::FUNC_NOTE_ON, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_NOTE_ON, 7'd127, 13'd0);
        send_item(na_pkg::FUNC_NOTE_ON, 7'd60, 13'd0);
        send_item(na_pkg::FUNC_NOTE_ON, 7'd60, 13'd0);
        send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd4096);
        send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd4096);
        send_item(na_pkg::FUNC_STEP, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_STOP, 7'd0, 13'd0);
        send_item(3'd5, 7'd1, 13'd1);
        send_item(3'd7, 7'd127, 13'd8191);
        send_item(na_pkg::FUNC_NOTE_OFF, 7'd99, 13'd0);
        send_item(na_pkg::FUNC_NOTE_OFF, 7'd0, 13'd0);
        drain();
        // Host clock, chord, widest octave span
        write_reg(na_pkg::REG_CLOCK_SOURCE, 24'(na_pkg::CLK_HOST));
        write_reg(na_pkg::REG_ARP_MODE, 24'(na_pkg::MODE_CHORD));
        write_reg(na_pkg::REG_OCTAVE_SPAN, 24'd7);
        send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd4096);
        repeat (7) send_item(na_pkg::FUNC_STEP, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_STOP, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_STOP, 7'd0, 13'd0);
        drain();
    endtask

    task automatic test_full_list();
        write_reg(na_pkg::REG_OCTAVE_SPAN, 24'd0);
        for (int i = 0; i < 17; i++)
            send_item(na_pkg::FUNC_NOTE_ON, 7'(i * 7 + 3), 13'd0);
        send_item(na_pkg::FUNC_STEP, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_NOTE_OFF, 7'd3, 13'd0);
        send_item(na_pkg::FUNC_STEP, 7'd0, 13'd0);
        drain();
    endtask

    task automatic test_disabled();
        write_reg(na_pkg::REG_ENABLED, 24'd0);
        send_item(na_pkg::FUNC_STEP, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_NOTE_ON, 7'd10, 13'd0);
        send_item(na_pkg::FUNC_STOP, 7'd0, 13'd0);
        drain();
        write_reg(na_pkg::REG_ENABLED, 24'd1);
        // Zero and extreme periods on the internal clock
        write_reg(na_pkg::REG_CLOCK_SOURCE, 24'(na_pkg::CLK_INTERNAL));
        write_reg(na_pkg::REG_ARP_MODE, 24'(na_pkg::MODE_BOUNCE));
        write_reg(na_pkg::REG_STEP_PERIOD, 24'd0);
        repeat (3) send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd0);
        send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd1);
        drain();
        write_reg(na_pkg::REG_STEP_PERIOD, 24'hFFFFFF);
        send_item(na_pkg::FUNC_ADVANCE, 7'd0, 13'd4096);
        drain();
    endtask

    // Block the receiver for a long stretch while chords keep coming
    task automatic test_backpressure();
        write_reg(na_pkg::REG_ENABLED, 24'd1);
        write_reg(na_pkg::REG_CLOCK_SOURCE, 24'(na_pkg::CLK_HOST));
        write_reg(na_pkg::REG_ARP_MODE, 24'(na_pkg::MODE_CHORD));
        write_reg(na_pkg::REG_OCTAVE_SPAN, 24'd4);
        for (int i = 0; i < 4; i++)
            send_item(na_pkg::FUNC_NOTE_ON, 7'(40 + i * 5), 13'd0);
        hold_off = 400;
        for (int i = 0; i < 12; i++) send_item(na_pkg::FUNC_STEP, 7'd0, 13'd0);
        drain();
    endtask

    task automatic test_random(input int phases, input int items);
        logic [6:0] pool [8];
        logic [2:0] f;
        logic [6:0] n;
        logic [12:0] c;
        int r;
        for (int ph = 0; ph < phases; ph++) begin
            write_reg(na_pkg::REG_ENABLED, 24'($urandom_range(9) != 0));
            write_reg(na_pkg::REG_CLOCK_SOURCE, 24'($urandom_range(1)));
            write_reg(na_pkg::REG_ARP_MODE, 24'($urandom_range(3)));
            write_reg(na_pkg::REG_OCTAVE_SPAN, 24'($urandom_range(7)));
            r = $urandom_range(9);
            write_reg(na_pkg::REG_STEP_PERIOD, (r == 0) ? 24'd1 : (r == 1) ? 24'hFFFFFF
                                             : 24'($urandom_range(8000, 1)));
            foreach (pool[i]) pool[i] = 7'($urandom_range(127));
            pool[0] = 7'd127;
            for (int k = 0; k < items; k++) begin
                r = $urandom_range(99);
                n = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                             : pool[$urandom_range(7)];
                c = 13'($urandom_range(4096));
                if (r < 35) f = na_pkg::FUNC_NOTE_ON;
                else if (r < 55) f = na_pkg::FUNC_NOTE_OFF;
                else if (r < 90)
                    f = (arp_src == na_pkg::CLK_HOST) ? na_pkg::FUNC_STEP
                                                      : na_pkg::FUNC_ADVANCE;
                else if (r < 95) f = na_pkg::FUNC_STOP;
                else f = 3'($urandom_range(7));
                send_item(f, n, c);
            end
            drain();
        end
    endtask

    initial begin
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 53;
        test_directed();
        test_full_list();
        test_disabled();
        test_random(3, 24);

        send_idle_pct = 53;
        recv_idle_pct = 34;
        test_backpressure();
        test_random(3, 24);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(3, 24);

        drain();
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d, results outstanding: %0d",
                     mismatches, expected_events.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
